// ----- src/ltrm_pkg.sv -----
`default_nettype none

package ltrm_pkg;

    localparam logic [2:0] CMD_FILL   = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_LOOKUP = 3'd2;
    localparam logic [2:0] CMD_UP     = 3'd3;
    localparam logic [2:0] CMD_DOWN   = 3'd4;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PAINT,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic latch;
        logic rd_en;
        logic layer_up;
        logic layer_down;
        logic paint;
        logic sweep;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       rect_empty;
        logic       paint_last;
        logic       layer_sweep_last;
        logic       all_sweep_last;
        logic       can_up;
        logic       can_down;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/ltrm_ctrl.sv -----
`default_nettype none

module ltrm_ctrl
    import ltrm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t st,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep = 1'b1;
                if (st.all_sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_RESULT;
                case (st.op)
                    CMD_FILL, CMD_CLEAR: begin
                        if (!st.rect_empty) begin
                            state_next = ST_PAINT;
                        end
                    end
                    CMD_LOOKUP: begin
                        cmd.rd_en = 1'b1;
                    end
                    CMD_UP: begin
                        if (st.can_up) begin
                            cmd.layer_up = 1'b1;
                            state_next   = ST_SWEEP;
                        end
                    end
                    CMD_DOWN: begin
                        cmd.layer_down = st.can_down;
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_PAINT: begin
                cmd.paint = 1'b1;
                if (st.paint_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (st.layer_sweep_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    a_one_beat_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> st.out_free)
        else $error("result loaded over an untaken result");

    a_result_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> state_reg == ST_IDLE)
        else $error("no return to idle after result");

endmodule

`default_nettype wire

// ----- src/ltrm_dp.sv -----
`default_nettype none

module ltrm_dp
    import ltrm_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int LAYERS     = 3
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctrl_cmd_t  cmd,
    output dp_status_t      st,
    input  wire logic       cfg_valid,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    input  wire logic [2:0] s_cmd,
    input  wire logic [7:0] s_x_pos,
    input  wire logic [7:0] s_y_pos,
    input  wire logic [8:0] s_rect_width,
    input  wire logic [8:0] s_rect_height,
    input  wire logic [7:0] s_widget_id,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_hit_id,
    output logic [1:0]      m_active_layer
);

    localparam int WCAP_I = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int HCAP_I = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
    localparam logic [8:0] WCAP = 9'(WCAP_I);
    localparam logic [8:0] HCAP = 9'(HCAP_I);
    localparam int XB    = $clog2(WCAP_I);
    localparam int YB    = $clog2(HCAP_I);
    localparam int PB    = XB + YB;
    localparam int LB    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int DEPTH = LAYERS * (1 << PB);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LB-1:0] LAYER_TOP = LB'(LAYERS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

    logic [7:0] mem [0:DEPTH-1];

    logic [8:0]    sw_reg;
    logic [8:0]    sh_reg;
    logic [2:0]    op_reg;
    logic [7:0]    x_reg;
    logic [7:0]    y_reg;
    logic [7:0]    id_reg;
    logic [7:0]    x_last_reg;
    logic [7:0]    y_last_reg;
    logic          rect_empty_reg;
    logic          in_screen_reg;
    logic [7:0]    col_reg;
    logic [7:0]    row_reg;
    logic [LB-1:0] layer_reg;
    logic [LB-1:0] layer_next;
    logic [AW-1:0] sweep_reg;
    logic [7:0]    rd_data_reg;
    logic          m_valid_reg;
    logic [7:0]    m_hit_id_reg;
    logic [1:0]    m_active_layer_reg;

    logic [9:0]        x_sum;
    logic [9:0]        y_sum;
    logic [8:0]        x_end;
    logic [8:0]        y_end;
    logic [LB+PB-1:0]  pix_full;
    logic [LB+PB-1:0]  look_full;
    logic [LB+PB-1:0]  init_full;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= WCAP;
            sh_reg <= HCAP;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SCREEN_WIDTH: begin
                    sw_reg <= (cfg_data > WCAP) ? WCAP : cfg_data;
                end
                REG_SCREEN_HEIGHT: begin
                    sh_reg <= (cfg_data > HCAP) ? HCAP : cfg_data;
                end
                default: begin
                    sw_reg <= sw_reg;
                end
            endcase
        end
    end

    assign x_sum = {2'b00, s_x_pos} + {1'b0, s_rect_width};
    assign y_sum = {2'b00, s_y_pos} + {1'b0, s_rect_height};
    assign x_end = (x_sum > {1'b0, sw_reg}) ? sw_reg : x_sum[8:0];
    assign y_end = (y_sum > {1'b0, sh_reg}) ? sh_reg : y_sum[8:0];

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg         <= s_cmd;
            x_reg          <= s_x_pos;
            y_reg          <= s_y_pos;
            id_reg         <= s_widget_id;
            x_last_reg     <= 8'(x_end - 9'd1);
            y_last_reg     <= 8'(y_end - 9'd1);
            rect_empty_reg <= ({1'b0, s_x_pos} >= sw_reg) || ({1'b0, s_y_pos} >= sh_reg) ||
                              (s_rect_width == 9'd0) || (s_rect_height == 9'd0);
            in_screen_reg  <= ({1'b0, s_x_pos} < sw_reg) && ({1'b0, s_y_pos} < sh_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            col_reg <= s_x_pos;
            row_reg <= s_y_pos;
        end else if (cmd.paint) begin
            if (col_reg == x_last_reg) begin
                col_reg <= x_reg;
                row_reg <= row_reg + 8'd1;
            end else begin
                col_reg <= col_reg + 8'd1;
            end
        end
    end

    assign layer_next = layer_reg + LB'(1);
    assign init_full  = {layer_next, {PB{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_reg <= '0;
            sweep_reg <= '0;
        end else begin
            if (cmd.layer_up) begin
                layer_reg <= layer_next;
                sweep_reg <= init_full[AW-1:0];
            end else if (cmd.sweep) begin
                sweep_reg <= sweep_reg + AW'(1);
            end
            if (cmd.layer_down) begin
                layer_reg <= layer_reg - LB'(1);
            end
        end
    end

    assign pix_full  = {layer_reg, row_reg[YB-1:0], col_reg[XB-1:0]};
    assign look_full = {layer_reg, y_reg[YB-1:0], x_reg[XB-1:0]};
    assign wr_addr   = cmd.paint ? pix_full[AW-1:0] : sweep_reg;
    assign wr_data   = (cmd.paint && op_reg == CMD_FILL) ? id_reg : 8'd0;

    always_ff @(posedge aclk) begin
        if (cmd.paint || cmd.sweep) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[look_full[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_hit_id_reg       <= (op_reg == CMD_LOOKUP && in_screen_reg) ? rd_data_reg : 8'd0;
            m_active_layer_reg <= 2'(layer_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit_id       = m_hit_id_reg;
    assign m_active_layer = m_active_layer_reg;

    always_comb begin
        st                  = '0;
        st.op               = op_reg;
        st.rect_empty       = rect_empty_reg;
        st.paint_last       = (col_reg == x_last_reg) && (row_reg == y_last_reg);
        st.layer_sweep_last = (sweep_reg[PB-1:0] == {PB{1'b1}});
        st.all_sweep_last   = (sweep_reg == ADDR_LAST);
        st.can_up           = (layer_reg != LAYER_TOP);
        st.can_down         = (layer_reg != '0);
        st.out_free         = !m_valid_reg || m_ready;
    end

    a_paint_inside_rect: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.paint |-> !rect_empty_reg && row_reg <= y_last_reg && col_reg <= x_last_reg &&
                      col_reg >= x_reg && row_reg >= y_reg)
        else $error("pixel write outside the clipped rectangle");

    a_layer_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        layer_reg <= LAYER_TOP)
        else $error("active layer beyond the top layer");

endmodule

`default_nettype wire

// ----- src/layered_touch_region_map.sv -----
`default_nettype none

// Per-pixel widget-id map for LAYERS screen layers, used for touch hit-testing.
// All map traffic goes through one memory write port and one registered read
// port, one pixel per cycle. A lookup reads one pixel into the read register,
// and its result beat is offered once the output register is free; a fill or
// clear writes each pixel of the clipped rectangle (an empty one writes none);
// layer up sweeps the whole new layer of 2^(XB+YB) pixels, where XB and YB are
// the address bits of min(MAX_WIDTH,256) and min(MAX_HEIGHT,256) (65536 at the
// defaults); layer down and unknown commands touch no pixel. After reset the
// block clears every layer, LAYERS * 2^(XB+YB) pixels (196608 at the defaults),
// and holds s_ready low until done. The configuration port is always ready. A
// result waits in an output register; the next beat is taken once the previous
// result is loaded there.
module layered_touch_region_map
    import ltrm_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int LAYERS     = 3
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_cmd,
    input  wire logic [7:0] s_x_pos,
    input  wire logic [7:0] s_y_pos,
    input  wire logic [8:0] s_rect_width,
    input  wire logic [8:0] s_rect_height,
    input  wire logic [7:0] s_widget_id,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_hit_id,
    output logic [1:0]      m_active_layer
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    ltrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ltrm_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .LAYERS     (LAYERS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_cmd          (s_cmd),
        .s_x_pos        (s_x_pos),
        .s_y_pos        (s_y_pos),
        .s_rect_width   (s_rect_width),
        .s_rect_height  (s_rect_height),
        .s_widget_id    (s_widget_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit_id       (m_hit_id),
        .m_active_layer (m_active_layer)
    );

endmodule

`default_nettype wire
